@@ rtl/core/conjugate_chirp_generator_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the conjugate chirp generator
// Shared property wrappers; every check is clocked on clk and off during rst.
// ----------------------------------------------------------------------------
`ifndef CONJUGATE_CHIRP_GENERATOR_TOP_ASSERT_SVH
`define CONJUGATE_CHIRP_GENERATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CCG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/ccg_pkg.sv @@
// ----------------------------------------------------------------------------
// ccg_pkg
// Register map, widths and the sine quarter-wave generator function.
// ----------------------------------------------------------------------------
package ccg_pkg;

  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_LEN_BITS  = 21;
  localparam int APB_ADDR_BITS = 4;

  typedef logic [APB_ADDR_BITS-3:0] reg_idx_t;

  localparam reg_idx_t REG_FIRST_STEP   = 2'd0;
  localparam reg_idx_t REG_SWEEP_STEP   = 2'd1;
  localparam reg_idx_t REG_SAMPLE_COUNT = 2'd2;

  localparam logic [CFG_LEN_BITS-1:0] SAMPLE_COUNT_RESET = 21'd1024;

  // pi/2 in Q30
  localparam longint HALF_PI_Q30 = 64'd1686629713;

  // restoring shift-and-subtract quotient, elaboration only
  function automatic longint unsigned udiv_q(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // round(A*sin(k*(pi/2)/2^(tab_bits-2))), A = 2^(amp_bits-1)-1, by a Q30
  // Taylor series. Evaluated at elaboration only.
  function automatic longint quarter_sine(input int k, input int tab_bits,
                                          input int amp_bits);
    longint unsigned kx;
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint          amp;
    longint          amp_max;
    longint          q30_one;
    kx      = longint'(k);
    q30_one = longint'(1) << 30;
    amp_max = (longint'(1) << (amp_bits - 1)) - 1;
    x       = (kx * longint'(HALF_PI_Q30)) >> (tab_bits - 2);
    term    = x;
    sum     = longint'(x);
    for (int n = 1; n <= 10; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = udiv_q(term, 64'((2 * n) * (2 * n + 1)));
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > q30_one) begin
      sum = q30_one;
    end
    amp = (sum * amp_max + (q30_one >> 1)) >> 30;
    if (amp > amp_max) begin
      amp = amp_max;
    end
    return amp;
  endfunction

endpackage

@@ rtl/core/ccg_ram.sv @@
// ----------------------------------------------------------------------------
// ccg_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ccg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ rtl/core/conjugate_chirp_generator_top.sv @@
// ----------------------------------------------------------------------------
// conjugate_chirp_generator_top
// Quadratic-phase NCO giving conj(exp(j*2*pi*phase)), one sample per input transfer while the sample count is nonzero.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------
//  in      | in        | in_valid / in_stall        | restart
//  out     | out       | out_valid / out_stall      | real_part imag_part
//          |           |                            | sample_index last
//  cfg     | in        | psel penable pwrite pready | paddr pwdata prdata
//
//  One sample per clock while no stall holds the flow; an input transfer
//  passes the quarter-wave sine RAM read, then the output register.
//  After rst the sine RAM is loaded with 2^(TABLE_ADDR_BITS-2)+1 entries (257
//  by default); in_stall stays high meanwhile, configuration writes still land.
//  A stalled output holds the sample in flight; in_stall rises during the load,
//  or when the RAM stage and the stalled output register are both full.
// ----------------------------------------------------------------------------
module conjugate_chirp_generator_top #(
  parameter int PHASE_BITS      = 32,
  parameter int AMP_BITS        = 16,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int MAX_LENGTH      = 1048576
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ccg_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [ccg_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [ccg_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  // tick input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                restart,
  // samples
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [AMP_BITS-1:0]          real_part,
  output logic signed [AMP_BITS-1:0]          imag_part,
  output logic [((MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1)-1:0] sample_index,
  output logic                                last
);

  localparam int IDX_BITS   = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int LEN_BITS   = $clog2(MAX_LENGTH + 1);
  localparam int CMP_BITS   = (LEN_BITS > ccg_pkg::CFG_LEN_BITS) ? LEN_BITS
                                                                 : ccg_pkg::CFG_LEN_BITS;
  localparam int K_BITS     = TABLE_ADDR_BITS - 1;
  localparam int QUARTER    = 1 << (TABLE_ADDR_BITS - 2);
  localparam int ROM_DEPTH  = QUARTER + 1;
  localparam logic [K_BITS-1:0] QUARTER_K = K_BITS'(QUARTER);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0]                      first_step;
  logic [31:0]                      sweep_step;
  logic [ccg_pkg::CFG_LEN_BITS-1:0] sample_count;
  ccg_pkg::reg_idx_t                reg_idx;
  logic                             cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ccg_pkg::APB_ADDR_BITS-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_step   <= '0;
      sweep_step   <= '0;
      sample_count <= ccg_pkg::SAMPLE_COUNT_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        ccg_pkg::REG_FIRST_STEP:   first_step   <= pwdata;
        ccg_pkg::REG_SWEEP_STEP:   sweep_step   <= pwdata;
        ccg_pkg::REG_SAMPLE_COUNT: sample_count <= pwdata[ccg_pkg::CFG_LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ccg_pkg::REG_FIRST_STEP:   prdata = first_step;
      ccg_pkg::REG_SWEEP_STEP:   prdata = sweep_step;
      ccg_pkg::REG_SAMPLE_COUNT: prdata = ccg_pkg::CFG_DATA_BITS'(sample_count);
      default:                   prdata = '0;
    endcase
  end

  // sign-extend the 32-bit steps, then keep PHASE_BITS of them
  logic [63:0]           first_wide;
  logic [63:0]           sweep_wide;
  logic [PHASE_BITS-1:0] first_ext;
  logic [PHASE_BITS-1:0] sweep_ext;

  assign first_wide = {{32{first_step[31]}}, first_step};
  assign sweep_wide = {{32{sweep_step[31]}}, sweep_step};
  assign first_ext  = first_wide[PHASE_BITS-1:0];
  assign sweep_ext  = sweep_wide[PHASE_BITS-1:0];

  // --------------------------------------------------------------------------
  // Sine RAM load after reset
  // --------------------------------------------------------------------------
  logic [AMP_BITS-1:0] qtab [ROM_DEPTH];

  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_qtab
    localparam logic [AMP_BITS-1:0] QVAL =
      AMP_BITS'(ccg_pkg::quarter_sine(g, TABLE_ADDR_BITS, AMP_BITS));
    assign qtab[g] = QVAL;
  end

  logic              fill_busy;
  logic [K_BITS-1:0] fill_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_busy <= 1'b1;
      fill_idx  <= '0;
    end else if (fill_busy) begin
      if (fill_idx == QUARTER_K) begin
        fill_busy <= 1'b0;
      end
      fill_idx <= fill_idx + K_BITS'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Accumulators and sample issue
  // --------------------------------------------------------------------------
  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] step_acc;
  logic [IDX_BITS-1:0]   index_count;

  logic                  s1_valid;
  logic                  s1_sin_neg;
  logic                  s1_cos_neg;
  logic [IDX_BITS-1:0]   s1_index;
  logic                  s1_last;

  logic                  can_adv;
  logic                  take;

  logic [CMP_BITS-1:0]   len;
  logic [CMP_BITS-1:0]   cnt_ext;
  logic                  len_zero;
  logic [IDX_BITS-1:0]   idx0;
  logic                  start;
  logic                  is_last;
  logic [PHASE_BITS-1:0] ph;
  logic [PHASE_BITS-1:0] st;

  logic [TABLE_ADDR_BITS-1:0] taddr;
  logic [1:0]                 quad_s;
  logic [1:0]                 quad_c;
  logic [K_BITS-1:0]          r_ext;
  logic [K_BITS-1:0]          k_sin;
  logic [K_BITS-1:0]          k_cos;
  logic [AMP_BITS-1:0]        sin_mag;
  logic [AMP_BITS-1:0]        cos_mag;

  assign can_adv  = !out_valid || !out_stall;
  assign in_stall = fill_busy || (s1_valid && !can_adv);
  assign take     = in_valid && !in_stall;

  assign cnt_ext  = CMP_BITS'(sample_count);
  assign len      = (cnt_ext > CMP_BITS'(MAX_LENGTH)) ? CMP_BITS'(MAX_LENGTH) : cnt_ext;
  assign len_zero = (len == '0);
  assign idx0     = restart ? '0 : index_count;
  assign start    = (idx0 == '0);
  assign is_last  = (CMP_BITS'(idx0) + CMP_BITS'(1)) >= len;
  // sample zero starts from phase zero and the configured first step
  assign ph       = start ? '0 : phase_acc;
  assign st       = start ? first_ext : step_acc;

  // quarter-wave folding of the sine and cosine addresses
  assign taddr  = ph[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  assign quad_s = taddr[TABLE_ADDR_BITS-1 -: 2];
  assign quad_c = quad_s + 2'd1;
  assign r_ext  = K_BITS'(taddr[TABLE_ADDR_BITS-3:0]);
  assign k_sin  = quad_s[0] ? (QUARTER_K - r_ext) : r_ext;
  assign k_cos  = quad_c[0] ? (QUARTER_K - r_ext) : r_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc   <= '0;
      step_acc    <= '0;
      index_count <= '0;
      s1_valid    <= 1'b0;
    end else if (take) begin
      s1_valid <= !len_zero;
      if (len_zero) begin
        index_count <= idx0;
      end else if (is_last) begin
        index_count <= '0;
        phase_acc   <= ph;
        step_acc    <= st;
      end else begin
        index_count <= idx0 + IDX_BITS'(1);
        phase_acc   <= ph + st;
        step_acc    <= st + sweep_ext;
      end
    end else if (can_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_sin_neg <= quad_s[1];
      s1_cos_neg <= quad_c[1];
      s1_index   <= idx0;
      s1_last    <= is_last;
    end
  end

  ccg_ram #(
    .WIDTH (AMP_BITS),
    .DEPTH (ROM_DEPTH)
  ) u_sine_ram (
    .clk     (clk),
    .we      (fill_busy),
    .waddr   (fill_idx),
    .wdata   (qtab[fill_idx]),
    .re      (take),
    .raddr_a (k_sin),
    .raddr_b (k_cos),
    .rdata_a (sin_mag),
    .rdata_b (cos_mag)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && can_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // the imaginary part is the negated sine
  always_ff @(posedge clk) begin
    if (s1_valid && can_adv) begin
      real_part    <= s1_cos_neg ? (AMP_BITS'(0) - cos_mag) : cos_mag;
      imag_part    <= s1_sin_neg ? sin_mag : (AMP_BITS'(0) - sin_mag);
      sample_index <= s1_index;
      last         <= s1_last;
    end
  end

endmodule

@@ rtl/core/ccg_checker.sv @@
// ----------------------------------------------------------------------------
// ccg_checker
// Port-level checks on the sample stream of the chirp generator.
// ----------------------------------------------------------------------------
`include "conjugate_chirp_generator_top_assert.svh"

module ccg_checker #(
  parameter int AMP_BITS = 16,
  parameter int IDX_BITS = 20
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [AMP_BITS-1:0] real_part,
  input logic signed [AMP_BITS-1:0] imag_part,
  input logic [IDX_BITS-1:0]        sample_index,
  input logic                       last
);

  localparam logic [AMP_BITS-1:0] AMP_MIN = {1'b1, {(AMP_BITS-1){1'b0}}};

  logic                out_xfer;
  logic                after_last;
  logic [IDX_BITS-1:0] prev_idx;

  assign out_xfer = out_valid && !out_stall;

  // a sweep begins after reset and after every last sample
  always_ff @(posedge clk) begin
    if (rst) begin
      after_last <= 1'b1;
      prev_idx   <= '0;
    end else if (out_xfer) begin
      after_last <= last;
      prev_idx   <= sample_index;
    end
  end

  `CCG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(real_part) && $stable(imag_part) && $stable(sample_index) && $stable(last), "stalled sample changed")

  `CCG_ASSERT_NOW(a_sweep_start, out_xfer && after_last, sample_index == '0, "sweep did not start at sample zero")

  `CCG_ASSERT_NOW(a_index_step, out_xfer && !after_last, sample_index == IDX_BITS'(prev_idx + 1'b1) || sample_index == '0, "sample index skipped")

  `CCG_ASSERT_NOW(a_amp_range, out_valid, real_part != AMP_MIN && imag_part != AMP_MIN, "sample outside amplitude range")

endmodule

bind conjugate_chirp_generator_top ccg_checker #(
  .AMP_BITS (AMP_BITS),
  .IDX_BITS (IDX_BITS)
) u_ccg_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .real_part    (real_part),
  .imag_part    (imag_part),
  .sample_index (sample_index),
  .last         (last)
);
